// ===== rtl/cnv3_pkg.sv =====
`timescale 1ns / 1ps
package cnv3_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 32;
    localparam int ROW_SUM_W   = 34;
    localparam int RESULT_W    = 36;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 13;
    localparam int COEF_ROW_W  = 48;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COEF_ROW_TOP = 3'd2;
    localparam logic [2:0] REG_COEF_ROW_MID = 3'd3;
    localparam logic [2:0] REG_COEF_ROW_BOT = 3'd4;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]                  image_width;
        logic [HEIGHT_W-1:0]                     image_height;
        logic [KERNEL_SIZE-1:0][COEF_ROW_W-1:0]  coef_rows;
    } cnv3_cfg_t;

    typedef struct packed {
        logic                   have;
        logic                   last;
        logic [KERNEL_SIZE-1:0] row_mask;
        logic [KERNEL_SIZE-1:0] col_mask;
    } cnv3_ctrl_t;

endpackage

// ===== rtl/cnv3_cfg.sv =====
`timescale 1ns / 1ps
module cnv3_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cnv3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cnv3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cnv3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output cnv3_pkg::cnv3_cfg_t                 cfg
);
    import cnv3_pkg::*;

    logic [2:0]             reg_index;
    logic                   wr_en;
    logic [WIDTH_REG_W-1:0] image_width_reg;
    logic [HEIGHT_W-1:0]    image_height_reg;
    logic [COEF_ROW_W-1:0]  coef_top_reg;
    logic [COEF_ROW_W-1:0]  coef_mid_reg;
    logic [COEF_ROW_W-1:0]  coef_bot_reg;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:3];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 11'd1024;
            image_height_reg <= 13'd1024;
            coef_top_reg     <= '0;
            coef_mid_reg     <= '0;
            coef_bot_reg     <= '0;
        end else if (wr_en) begin
            case (reg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[HEIGHT_W-1:0];
                REG_COEF_ROW_TOP: coef_top_reg     <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_ROW_MID: coef_mid_reg     <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_ROW_BOT: coef_bot_reg     <= pwdata[COEF_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_index)
            REG_IMAGE_WIDTH:  prdata[WIDTH_REG_W-1:0] = image_width_reg;
            REG_IMAGE_HEIGHT: prdata[HEIGHT_W-1:0]    = image_height_reg;
            REG_COEF_ROW_TOP: prdata[COEF_ROW_W-1:0]  = coef_top_reg;
            REG_COEF_ROW_MID: prdata[COEF_ROW_W-1:0]  = coef_mid_reg;
            REG_COEF_ROW_BOT: prdata[COEF_ROW_W-1:0]  = coef_bot_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.image_width  = image_width_reg;
    assign cfg.image_height = image_height_reg;
    assign cfg.coef_rows[0] = coef_top_reg;
    assign cfg.coef_rows[1] = coef_mid_reg;
    assign cfg.coef_rows[2] = coef_bot_reg;

endmodule

// ===== rtl/cnv3_front.sv =====
`timescale 1ns / 1ps
module cnv3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cnv3_pkg::cnv3_cfg_t                  cfg,
    input  logic                                 accept,
    input  logic [cnv3_pkg::SAMPLE_W-1:0]        sample,
    input  logic                                 is_padding,
    output logic [cnv3_pkg::SAMPLE_W-1:0]        fresh,
    output logic [$clog2(MAX_WIDTH)-1:0]         addr,
    output cnv3_pkg::cnv3_ctrl_t                 ctrl
);
    import cnv3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]       col_count_reg, col_count_next;
    logic [HEIGHT_W-1:0] row_count_reg, row_count_next;
    logic [WW-1:0]       w_eff, x, col_ext;
    logic [HEIGHT_W-1:0] h_eff, y;
    logic                have_pos;

    always_comb begin
        if (cfg.image_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg.image_width);
        end
        if (cfg.image_height == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (cfg.image_height > HEIGHT_LIMIT) begin
            h_eff = HEIGHT_LIMIT;
        end else begin
            h_eff = cfg.image_height;
        end
    end

    // The output position trails the input by one row and one column.
    always_comb begin
        col_ext  = WW'(col_count_reg);
        have_pos = 1'b0;
        x        = '0;
        y        = '0;
        if (col_count_reg != '0 && row_count_reg != '0) begin
            have_pos = 1'b1;
            x        = col_ext - WW'(1);
            y        = row_count_reg - HEIGHT_W'(1);
        end else if (col_count_reg == '0 && row_count_reg >= HEIGHT_W'(2)) begin
            have_pos = 1'b1;
            x        = w_eff - WW'(1);
            y        = row_count_reg - HEIGHT_W'(2);
        end
        ctrl.have        = have_pos && (y < h_eff);
        ctrl.last        = ctrl.have && (x == w_eff - WW'(1)) && (y == h_eff - HEIGHT_W'(1));
        ctrl.row_mask[0] = (y != '0);
        ctrl.row_mask[1] = (y < h_eff);
        ctrl.row_mask[2] = ((y + HEIGHT_W'(1)) < h_eff);
        ctrl.col_mask[0] = (x != '0) && (x <= w_eff);
        ctrl.col_mask[1] = (x < w_eff);
        ctrl.col_mask[2] = ((x + WW'(1)) < w_eff);
    end

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (ctrl.last || row_count_reg > h_eff) begin
            col_count_next = '0;
            row_count_next = '0;
        end else if ((col_ext + WW'(1)) >= w_eff) begin
            col_count_next = '0;
            row_count_next = row_count_reg + HEIGHT_W'(1);
        end else begin
            col_count_next = col_count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    assign fresh = is_padding ? '0 : sample;
    assign addr  = col_count_reg;

endmodule

// ===== rtl/cnv3_fifo.sv =====
`timescale 1ns / 1ps
module cnv3_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty,
    output logic              full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0]     count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == LW'(DEPTH));
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + LW'(1);
            2'b01:   count_next = count_reg - LW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/cnv3_back.sv =====
`timescale 1ns / 1ps
module cnv3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cnv3_pkg::cnv3_cfg_t                   cfg,
    input  logic                                  q_valid,
    input  logic [cnv3_pkg::SAMPLE_W-1:0]         q_fresh,
    input  logic [$clog2(MAX_WIDTH)-1:0]          q_addr,
    input  cnv3_pkg::cnv3_ctrl_t                  q_ctrl,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cnv3_pkg::RESULT_W-1:0]  m_result,
    output logic                                  m_last
);
    import cnv3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int K  = KERNEL_SIZE;

    logic                  adv;
    logic                  wr_en, byp_hit;
    logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
    logic [2*SAMPLE_W-1:0] rd_data_reg, byp_data_reg, line_rd, line_wr;
    logic                  byp_reg;

    logic                  s1_valid_reg;
    logic [SAMPLE_W-1:0]   s1_fresh_reg;
    logic [CW-1:0]         s1_addr_reg;
    cnv3_ctrl_t            s1_ctrl_reg;
    logic signed [SAMPLE_W-1:0] col [K];
    logic signed [SAMPLE_W-1:0] window_reg [K][K];

    logic                  s2_valid_reg;
    cnv3_ctrl_t            s2_ctrl_reg;
    logic signed [PROD_W-1:0] prod_next [K][K];

    logic                  s3_valid_reg, s3_last_reg;
    logic signed [PROD_W-1:0] prod_reg [K][K];
    logic signed [ROW_SUM_W-1:0] row_sum_next [K];

    logic                  s4_valid_reg, s4_last_reg;
    logic signed [ROW_SUM_W-1:0] row_sum_reg [K];
    logic signed [RESULT_W-1:0]  result_next;

    logic                  m_valid_reg, m_last_reg;
    logic signed [RESULT_W-1:0] m_result_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign q_pop   = adv && q_valid;
    assign wr_en   = s1_valid_reg && adv;
    assign byp_hit = wr_en && (q_addr == s1_addr_reg);

    // Line store entry: upper half is two rows back, lower half the previous row.
    assign line_rd = byp_reg ? byp_data_reg : rd_data_reg;
    assign line_wr = {line_rd[SAMPLE_W-1:0], s1_fresh_reg};
    assign col[0]  = line_rd[2*SAMPLE_W-1:SAMPLE_W];
    assign col[1]  = line_rd[SAMPLE_W-1:0];
    assign col[2]  = s1_fresh_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[s1_addr_reg] <= line_wr;
        end
        if (adv) begin
            rd_data_reg  <= line_mem[q_addr];
            byp_data_reg <= line_wr;
        end
    end

    genvar r, c;
    generate
        for (r = 0; r < K; r++) begin : g_row
            for (c = 0; c < K; c++) begin : g_col
                logic signed [SAMPLE_W-1:0] coef;
                assign coef = cfg.coef_rows[K-1-r][SAMPLE_W*(K-1-c) +: SAMPLE_W];
                assign prod_next[r][c] =
                    (s2_ctrl_reg.row_mask[r] && s2_ctrl_reg.col_mask[c]) ?
                    PROD_W'(window_reg[r][c] * coef) : '0;
            end
            assign row_sum_next[r] = ROW_SUM_W'(prod_reg[r][0]) + ROW_SUM_W'(prod_reg[r][1])
                                   + ROW_SUM_W'(prod_reg[r][2]);
        end
    endgenerate

    assign result_next = RESULT_W'(row_sum_reg[0]) + RESULT_W'(row_sum_reg[1])
                       + RESULT_W'(row_sum_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K; j++) begin
                    window_reg[i][j] <= '0;
                end
            end
        end else if (adv) begin
            byp_reg      <= byp_hit;
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg && s1_ctrl_reg.have;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
            if (s1_valid_reg) begin
                for (int i = 0; i < K; i++) begin
                    window_reg[i][0] <= window_reg[i][1];
                    window_reg[i][1] <= window_reg[i][2];
                    window_reg[i][2] <= col[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_fresh_reg <= q_fresh;
            s1_addr_reg  <= q_addr;
            s1_ctrl_reg  <= q_ctrl;
            s2_ctrl_reg  <= s1_ctrl_reg;
            s3_last_reg  <= s2_ctrl_reg.last;
            s4_last_reg  <= s3_last_reg;
            m_last_reg   <= s4_last_reg;
            m_result_reg <= result_next;
            for (int i = 0; i < K; i++) begin
                row_sum_reg[i] <= row_sum_next[i];
                for (int j = 0; j < K; j++) begin
                    prod_reg[i][j] <= prod_next[i][j];
                end
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== rtl/conv2d_3x3_zero_pad_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       s_tdata: sample; s_tuser: is_padding
// m_        out        m_tvalid / m_tready       m_tdata: result; m_tlast: last_of_frame
// APB       in         psel, penable, pready     pwdata / prdata, 64 bits, register i at 8*i
//
// One item is taken per clock while the input queue is not full; after it leaves the input queue
// its result passes through the line store read, the window register, the multiplier stage and two
// adder stages.
// Reset is synchronous and active low; the line stores are not cleared and need no clearing pass.
// A stalled result freezes the back pipeline; the four-entry input queue keeps accepting until full.
module conv2d_3x3_zero_pad_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cnv3_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] sample
    input  logic [0:0]                         s_tuser,   // [0] is_padding
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cnv3_pkg::M_TDATA_W-1:0]     m_tdata,   // [35:0] result, [39:36] zero
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cnv3_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cnv3_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cnv3_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import cnv3_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CTRL_W = $bits(cnv3_ctrl_t);
    localparam int Q_W    = CTRL_W + CW + SAMPLE_W;

    cnv3_cfg_t             cfg;
    logic                  s_accept;
    logic [SAMPLE_W-1:0]   f_fresh;
    logic [CW-1:0]         f_addr;
    cnv3_ctrl_t            f_ctrl;
    logic [Q_W-1:0]        q_wr_data, q_rd_data;
    logic                  q_empty, q_full, q_pop;
    logic [SAMPLE_W-1:0]   q_fresh;
    logic [CW-1:0]         q_addr;
    cnv3_ctrl_t            q_ctrl;
    logic signed [RESULT_W-1:0] result;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    cnv3_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cnv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (s_accept),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .is_padding (s_tuser[0]),
        .fresh      (f_fresh),
        .addr       (f_addr),
        .ctrl       (f_ctrl)
    );

    assign q_wr_data = {f_ctrl, f_addr, f_fresh};

    cnv3_fifo #(.DATA_W(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_accept),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    assign q_fresh = q_rd_data[SAMPLE_W-1:0];
    assign q_addr  = q_rd_data[SAMPLE_W +: CW];
    assign q_ctrl  = q_rd_data[Q_W-1 -: CTRL_W];

    cnv3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (!q_empty),
        .q_fresh  (q_fresh),
        .q_addr   (q_addr),
        .q_ctrl   (q_ctrl),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, result};

    a_no_pop_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("queue popped while the result register is stalled");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_centre_row_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && f_ctrl.have) |-> f_ctrl.row_mask[1])
        else $error("result position classified outside the image rows");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import cnv3_pkg::*;

    localparam int LINE_DEPTH      = 1024;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int STALL_CYCLES    = 300;

    localparam logic [RESULT_W-1:0] CORNER_SUM = 36'h1_0000_0000;
    localparam logic [RESULT_W-1:0] EDGE_SUM   = 36'h1_8000_0000;
    localparam logic [RESULT_W-1:0] CENTRE_SUM = 36'h2_4000_0000;

    typedef struct {
        logic [RESULT_W-1:0] result;
        logic                last;
    } pixel_out_t;

    typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_TYPED} out_rule_e;

    typedef struct {
        bit                  is_reg;
        logic [2:0]          reg_idx;
        logic [63:0]         value;
        logic                pad;
        out_rule_e           rule;
        logic [RESULT_W-1:0] result;
        logic                last;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [WIDTH_REG_W-1:0] width_reg  = 11'd1024;
    logic [HEIGHT_W-1:0]    height_reg = 13'd1024;
    logic [COEF_ROW_W-1:0]  coef_row [KERNEL_SIZE] = '{default: '0};
    logic [15:0]            near_row [LINE_DEPTH] = '{default: '0};
    logic [15:0]            far_row [LINE_DEPTH] = '{default: '0};
    logic [15:0]            taps [KERNEL_SIZE][KERNEL_SIZE] = '{default: '{default: '0}};
    int                     col_pos = 0;
    int                     row_pos = 0;

    pixel_out_t pending [$];
    plan_row_t  plan [$];
    pixel_out_t head;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         items_sent = 0;
    int         send_idle_pct = 0;
    int         take_idle_pct = 0;
    int         stall_left = 0;
    bit         stall_request = 1'b0;

    conv2d_3x3_zero_pad_unit #(.MAX_WIDTH(LINE_DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int active_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg == 0) return 1;
        if (height_reg > HEIGHT_LIMIT) return int'(HEIGHT_LIMIT);
        return int'(height_reg);
    endfunction

    function automatic logic [63:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_IMAGE_WIDTH:  return 64'(width_reg);
            REG_IMAGE_HEIGHT: return 64'(height_reg);
            REG_COEF_ROW_TOP: return 64'(coef_row[0]);
            REG_COEF_ROW_MID: return 64'(coef_row[1]);
            REG_COEF_ROW_BOT: return 64'(coef_row[2]);
            default:          return '0;
        endcase
    endfunction

    function automatic logic [COEF_ROW_W-1:0] pick_coef_row();
        logic [COEF_ROW_W-1:0] v;
        for (int c = 0; c < KERNEL_SIZE; c++) begin
            case ($urandom_range(5))
                0:       v[16*c +: 16] = 16'h8000;
                1:       v[16*c +: 16] = 16'h7FFF;
                2:       v[16*c +: 16] = 16'h0000;
                3:       v[16*c +: 16] = 16'h0100;
                default: v[16*c +: 16] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    // Advances the raster position by one item and works out the pixel it completes.
    function automatic void conv_predict(input logic [15:0] smp, input logic pad,
                                         output bit got, output pixel_out_t px);
        int w, h, cx, cy, idx, x, y, yr, xc;
        logic [15:0] fresh;
        logic [15:0] col [KERNEL_SIZE];
        logic signed [15:0] k, s;
        longint total;
        bit lst;
        w = active_width();
        h = active_height();
        cx = col_pos;
        cy = row_pos;
        idx = (cx < LINE_DEPTH) ? cx : LINE_DEPTH - 1;
        fresh = pad ? 16'h0000 : smp;
        col[0] = far_row[idx];
        col[1] = near_row[idx];
        col[2] = fresh;
        far_row[idx] = near_row[idx];
        near_row[idx] = fresh;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            taps[r][0] = taps[r][1];
            taps[r][1] = taps[r][2];
            taps[r][2] = col[r];
        end
        got = 1'b0;
        lst = 1'b0;
        x = 0;
        y = 0;
        if (cx >= 1 && cy >= 1) begin
            got = 1'b1;
            x = cx - 1;
            y = cy - 1;
        end else if (cx == 0 && cy >= 2) begin
            got = 1'b1;
            x = w - 1;
            y = cy - 2;
        end
        if (got && y >= h) got = 1'b0;
        px.result = '0;
        px.last = 1'b0;
        if (got) begin
            total = 0;
            lst = (x == w - 1) && (y == h - 1);
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                yr = y + r;
                if (yr < 1 || yr - 1 >= h) continue;
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    xc = x + c;
                    if (xc < 1 || xc - 1 >= w) continue;
                    k = coef_row[KERNEL_SIZE-1-r][16*(KERNEL_SIZE-1-c) +: 16];
                    s = taps[r][c];
                    total += longint'(k) * longint'(s);
                end
            end
            px.result = total[RESULT_W-1:0];
            px.last = lst;
        end
        if (lst || cy >= h + 1) begin
            col_pos = 0;
            row_pos = 0;
        end else if (cx + 1 >= w) begin
            col_pos = 0;
            row_pos = cy + 1;
        end else begin
            col_pos = cx + 1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 100)
            $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic read_reg(input logic [2:0] idx, output logic [63:0] val);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 3'b000};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        val = prdata;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        logic [63:0] got;
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg = val[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_W-1:0];
            REG_COEF_ROW_TOP: coef_row[0] = val[COEF_ROW_W-1:0];
            REG_COEF_ROW_MID: coef_row[1] = val[COEF_ROW_W-1:0];
            REG_COEF_ROW_BOT: coef_row[2] = val[COEF_ROW_W-1:0];
            default: ;
        endcase
        read_reg(idx, got);
        if (got !== reg_value(idx)) report_mismatch("register readback", got, reg_value(idx));
    endtask

    task automatic send_item(input logic [15:0] smp, input logic pad);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = smp;
        s_tuser = pad;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        items_sent++;
    endtask

    // Items that complete no pixel may still be in flight, hence the extra cycles.
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic plan_reg(input logic [2:0] idx, input logic [63:0] val);
        plan_row_t row;
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.value = val;
        row.pad = 1'b0;
        row.rule = OUT_MODEL;
        row.result = '0;
        row.last = 1'b0;
        plan.push_back(row);
    endtask

    task automatic plan_item(input logic [15:0] smp, input logic pad, input out_rule_e rule,
                             input logic [RESULT_W-1:0] res, input logic lst);
        plan_row_t row;
        row.is_reg = 1'b0;
        row.reg_idx = REG_IMAGE_WIDTH;
        row.value = 64'(smp);
        row.pad = pad;
        row.rule = rule;
        row.result = res;
        row.last = lst;
        plan.push_back(row);
    endtask

    // Streams items until the raster position wraps back to the start of a frame.
    task automatic run_frame(input int cut_at, input logic [63:0] cut_height);
        int n;
        logic pad;
        logic [15:0] smp;
        bit got;
        pixel_out_t px;
        n = 0;
        do begin
            if (n == cut_at) begin
                settle();
                write_reg(REG_IMAGE_HEIGHT, cut_height);
            end
            pad = (row_pos >= active_height());
            if ($urandom_range(39) == 0) pad = !pad;
            case ($urandom_range(7))
                0:       smp = 16'h8000;
                1:       smp = 16'h7FFF;
                2:       smp = 16'h0000;
                default: smp = 16'($urandom);
            endcase
            conv_predict(smp, pad, got, px);
            if (got) pending.push_back(px);
            send_item(smp, pad);
            n++;
        end while (col_pos != 0 || row_pos != 0);
    endtask

    task automatic random_frame();
        int cut_at;
        settle();
        if ($urandom_range(1))
            write_reg(REG_IMAGE_WIDTH, ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 9));
        if ($urandom_range(1))
            write_reg(REG_IMAGE_HEIGHT, ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 6));
        if ($urandom_range(2) == 0) write_reg(REG_COEF_ROW_TOP, pick_coef_row());
        if ($urandom_range(2) == 0) write_reg(REG_COEF_ROW_MID, pick_coef_row());
        if ($urandom_range(2) == 0) write_reg(REG_COEF_ROW_BOT, pick_coef_row());
        cut_at = ($urandom_range(4) == 0) ? int'($urandom_range(0, 40)) : -1;
        run_frame(cut_at, $urandom_range(0, 6));
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), 64'(0));
            end else begin
                head = pending.pop_front();
                if (m_tdata !== M_TDATA_W'(head.result))
                    report_mismatch("result", 64'(m_tdata), 64'(head.result));
                if (m_tlast !== head.last)
                    report_mismatch("last_of_frame", 64'(m_tlast), 64'(head.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int ri;
        int phase_start;
        logic [63:0] got64;
        bit got;
        pixel_out_t px;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (ri = REG_IMAGE_WIDTH; ri <= REG_COEF_ROW_BOT; ri++) begin
            read_reg(ri[2:0], got64);
            if (got64 !== reg_value(ri[2:0]))
                report_mismatch("register after reset", got64, reg_value(ri[2:0]));
        end

        // Single pixel frames: zero kernel, then a centre tap of 0x0100.
        plan_reg(REG_IMAGE_WIDTH, 64'd1);
        plan_reg(REG_IMAGE_HEIGHT, 64'd1);
        plan_item(16'h7FFF, 1'b0, OUT_NONE, '0, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_NONE, '0, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_TYPED, '0, 1'b1);
        plan_reg(REG_COEF_ROW_MID, 64'h0000_0000_0100_0000);
        plan_item(16'h7FFF, 1'b0, OUT_NONE, '0, 1'b0);
        plan_item(16'h5A5A, 1'b1, OUT_NONE, '0, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_TYPED, 36'h0_007F_FF00, 1'b1);
        // Most negative kernel and samples everywhere: the border taps show the masking.
        plan_reg(REG_COEF_ROW_TOP, 64'h0000_8000_8000_8000);
        plan_reg(REG_COEF_ROW_MID, 64'h0000_8000_8000_8000);
        plan_reg(REG_COEF_ROW_BOT, 64'h0000_8000_8000_8000);
        plan_reg(REG_IMAGE_WIDTH, 64'd3);
        plan_reg(REG_IMAGE_HEIGHT, 64'd3);
        plan_item(16'h8000, 1'b0, OUT_NONE, '0, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_NONE, '0, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_NONE, '0, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_NONE, '0, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_TYPED, CORNER_SUM, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_TYPED, EDGE_SUM, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_TYPED, CORNER_SUM, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_TYPED, EDGE_SUM, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_TYPED, CENTRE_SUM, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_TYPED, EDGE_SUM, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_TYPED, CORNER_SUM, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_TYPED, EDGE_SUM, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_TYPED, CORNER_SUM, 1'b1);
        // Flagged image pixel and an unflagged flush item.
        plan_reg(REG_IMAGE_WIDTH, 64'd2);
        plan_reg(REG_IMAGE_HEIGHT, 64'd1);
        plan_item(16'h1234, 1'b1, OUT_MODEL, '0, 1'b0);
        plan_item(16'h8000, 1'b0, OUT_MODEL, '0, 1'b0);
        plan_item(16'h7FFF, 1'b0, OUT_MODEL, '0, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_MODEL, '0, 1'b0);
        plan_item(16'h0000, 1'b1, OUT_MODEL, '0, 1'b0);

        send_idle_pct = 13;
        take_idle_pct = 87;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                conv_predict(plan[i].value[15:0], plan[i].pad, got, px);
                case (plan[i].rule)
                    OUT_TYPED: begin
                        if (!got || px.result !== plan[i].result || px.last !== plan[i].last)
                            report_mismatch("prediction against table", 64'(px.result),
                                            64'(plan[i].result));
                        px.result = plan[i].result;
                        px.last = plan[i].last;
                        pending.push_back(px);
                    end
                    OUT_NONE: begin
                        if (got) report_mismatch("prediction against table", 64'(1), 64'(0));
                    end
                    default: begin
                        if (got) pending.push_back(px);
                    end
                endcase
                send_item(plan[i].value[15:0], plan[i].pad);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    take_idle_pct = 87;
                end
                1: begin
                    send_idle_pct = 87;
                    take_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) random_frame();
        end

        // The output is held off long enough to back up the input.
        settle();
        write_reg(REG_IMAGE_WIDTH, 64'd8);
        write_reg(REG_IMAGE_HEIGHT, 64'd6);
        @(posedge aclk);
        stall_request = 1'b1;
        run_frame(-1, 64'd0);

        settle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== conv2d_3x3_zero_pad_unit.f =====
rtl/cnv3_pkg.sv
rtl/cnv3_cfg.sv
rtl/cnv3_front.sv
rtl/cnv3_fifo.sv
rtl/cnv3_back.sv
rtl/conv2d_3x3_zero_pad_unit.sv
verif/testbench.sv
